>>> rtl/sysex_pkg.sv
// ----------------------------------------------------------------------------
// sysex_pkg
// Shared constants and types for the system-exclusive 7-to-8 bit unpacker.
// ----------------------------------------------------------------------------
package sysex_pkg;

    localparam logic [7:0] START_BYTE   = 8'hF0;
    localparam logic [7:0] END_BYTE     = 8'hF7;
    localparam int         HEADER_BYTES = 6;
    localparam int         CHUNK_BITS   = 7;
    localparam int         GROUP_IN     = 8;
    localparam int         GROUP_OUT    = 7;
    localparam int         GROUP_BITS   = GROUP_IN * CHUNK_BITS;

    localparam logic [7:0]  POS_MFR_HI  = 8'd1;
    localparam logic [7:0]  POS_MFR_MID = 8'd2;
    localparam logic [7:0]  POS_MFR_LO  = 8'd3;
    localparam logic [7:0]  POS_COMMAND = 8'd5;
    localparam logic [7:0]  POS_DATA    = 8'(HEADER_BYTES);
    localparam logic [7:0]  POS_MAX     = 8'd255;

    localparam logic [23:0] MFR_ID_RESET   = 24'h00000E;
    localparam logic [6:0]  COMMAND_RESET  = 7'h03;
    localparam logic [7:0]  MAX_DATA_RESET = 8'd232;

    typedef enum logic [1:0] {
        CFG_MFR_ID   = 2'd0,
        CFG_COMMAND  = 2'd1,
        CFG_MAX_DATA = 2'd2
    } cfg_idx_t;

endpackage

>>> rtl/sysex_seven_to_eight_unpack.sv
// ----------------------------------------------------------------------------
// sysex_seven_to_eight_unpack
// Unpacks 7-bit system-exclusive payload bytes into packed 8-bit bytes.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_byte) takes one stream byte per
// item. A message ends at 0xF7. After a six byte header (0xF0, three
// manufacturer id bytes, one ignored byte, command byte) the low seven bits
// of data bytes are kept if the header matched, up to the data limit; every
// eighth kept byte completes a group and yields seven output items
// (out_valid / out_stall / out_byte), the seventh marked by last_of_group.
// Partial groups are dropped at 0xF7. Throughput is one input byte per cycle
// unless stalled. A byte is held in an input register and processed from
// there; a completed group is loaded into a 56-bit output shift register and
// drained one byte per cycle unless the receiver stalls, the first item
// offered once the completing byte is processed. The stream runs without
// gaps. When the receiver stalls, the input is stalled only when a byte that
// completes a group meets an output register still holding bytes of the
// previous group. Reset (rst_n low, asynchronous) clears the message state
// and drops any buffered output; configuration registers return to id
// 0x00000E, command 0x03 and a data limit of 232 bytes.
// ----------------------------------------------------------------------------
module sysex_seven_to_eight_unpack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_group,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int ACC_BITS = sysex_pkg::GROUP_BITS - sysex_pkg::CHUNK_BITS;

    // configuration
    logic [23:0] mfr_id_reg;
    logic [6:0]  command_reg;
    logic [7:0]  max_data_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // message state
    logic [7:0]          pos_reg, pos_next;
    logic                hdr_good_reg, hdr_good_next;
    logic [ACC_BITS-1:0] acc_reg, acc_next;
    logic [2:0]          fill_reg, fill_next;
    logic [7:0]          taken_reg, taken_next;

    // output shift register
    logic [sysex_pkg::GROUP_BITS-1:0] obuf_reg, obuf_next;
    logic [2:0]                       ocnt_reg, ocnt_next;

    logic                             group_done;
    logic [sysex_pkg::GROUP_BITS-1:0] group_bits;
    logic                             proc_go;
    logic                             in_accept;
    logic                             out_accept;
    logic [7:0]                       mfr_expect;

    assign out_valid     = (ocnt_reg != 3'd0);
    assign out_byte      = obuf_reg[sysex_pkg::GROUP_BITS-1 -: 8];
    assign last_of_group = (ocnt_reg == 3'd1);
    assign out_accept    = out_valid && !out_stall;

    assign group_bits = {acc_reg, in_byte_reg[6:0]};

    always_comb
    begin
        case (pos_reg)
            sysex_pkg::POS_MFR_HI:  mfr_expect = mfr_id_reg[23:16];
            sysex_pkg::POS_MFR_MID: mfr_expect = mfr_id_reg[15:8];
            default:                mfr_expect = mfr_id_reg[7:0];
        endcase
    end

    always_comb
    begin
        pos_next      = pos_reg;
        hdr_good_next = hdr_good_reg;
        acc_next      = acc_reg;
        fill_next     = fill_reg;
        taken_next    = taken_reg;
        group_done    = 1'b0;

        if (in_byte_reg == sysex_pkg::END_BYTE)
        begin
            pos_next      = '0;
            hdr_good_next = 1'b1;
            acc_next      = '0;
            fill_next     = '0;
            taken_next    = '0;
        end
        else
        begin
            if (pos_reg == 8'd0)
            begin
                hdr_good_next = (in_byte_reg == sysex_pkg::START_BYTE);
            end
            else if (pos_reg == sysex_pkg::POS_MFR_HI || pos_reg == sysex_pkg::POS_MFR_MID
                     || pos_reg == sysex_pkg::POS_MFR_LO)
            begin
                if (in_byte_reg != mfr_expect)
                    hdr_good_next = 1'b0;
            end
            else if (pos_reg == sysex_pkg::POS_COMMAND)
            begin
                if (in_byte_reg != {1'b0, command_reg})
                    hdr_good_next = 1'b0;
            end
            else if (pos_reg >= sysex_pkg::POS_DATA)
            begin
                if (hdr_good_reg && taken_reg < max_data_reg)
                begin
                    taken_next = taken_reg + 8'd1;
                    if (fill_reg == 3'(sysex_pkg::GROUP_IN - 1))
                    begin
                        group_done = 1'b1;
                        acc_next   = '0;
                        fill_next  = '0;
                    end
                    else
                    begin
                        acc_next  = group_bits[ACC_BITS-1:0];
                        fill_next = fill_reg + 3'd1;
                    end
                end
            end

            if (pos_reg != sysex_pkg::POS_MAX)
                pos_next = pos_reg + 8'd1;
        end
    end

    // A completing byte waits only while the output register is still busy.
    assign proc_go   = !group_done || (ocnt_reg == 3'd0)
                       || (ocnt_reg == 3'd1 && out_accept);
    assign in_stall  = in_valid_reg && !proc_go;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        obuf_next = obuf_reg;
        ocnt_next = ocnt_reg;
        if (out_accept)
        begin
            obuf_next = {obuf_reg[sysex_pkg::GROUP_BITS-9:0], 8'd0};
            ocnt_next = ocnt_reg - 3'd1;
        end
        if (in_valid_reg && proc_go && group_done)
        begin
            obuf_next = group_bits;
            ocnt_next = 3'(sysex_pkg::GROUP_OUT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mfr_id_reg   <= sysex_pkg::MFR_ID_RESET;
            command_reg  <= sysex_pkg::COMMAND_RESET;
            max_data_reg <= sysex_pkg::MAX_DATA_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                sysex_pkg::CFG_MFR_ID:   mfr_id_reg   <= cfg_data;
                sysex_pkg::CFG_COMMAND:  command_reg  <= cfg_data[6:0];
                sysex_pkg::CFG_MAX_DATA: max_data_reg <= cfg_data[7:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
            hdr_good_reg <= 1'b1;
            acc_reg      <= '0;
            fill_reg     <= '0;
            taken_reg    <= '0;
            ocnt_reg     <= '0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (proc_go)
                in_valid_reg <= 1'b0;

            if (in_valid_reg && proc_go)
            begin
                pos_reg      <= pos_next;
                hdr_good_reg <= hdr_good_next;
                acc_reg      <= acc_next;
                fill_reg     <= fill_next;
                taken_reg    <= taken_next;
            end

            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_byte_reg <= in_byte;
        obuf_reg <= obuf_next;
    end

endmodule
